### rtl/core/smu_pkg.sv
package smu_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 32;
  localparam int FIELD_W      = 32;
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  typedef struct packed {
    logic valid;
    seg_t seg;
  } slot_t;

  typedef struct packed {
    seg_t seg;
    logic swap_x;
    logic swap_y;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic axis;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic last;
    seg_t seg;
  } merge_out_t;

  function automatic coord_t start_of(seg_t s, logic axis);
    return axis ? s.ay : s.ax;
  endfunction

  function automatic coord_t end_of(seg_t s, logic axis);
    return axis ? s.by : s.bx;
  endfunction

  function automatic seg_t orient(entry_t e, logic axis);
    seg_t r;
    r = e.seg;
    if (axis ? e.swap_y : e.swap_x) begin
      r.ax = e.seg.bx;
      r.ay = e.seg.by;
      r.bx = e.seg.ax;
      r.by = e.seg.ay;
    end
    return r;
  endfunction

endpackage

### rtl/core/smu_cell.sv
module smu_cell
  import smu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  seg_t       new_seg,
  input  slot_t      left,
  input  logic       left_take,
  input  slot_t      right,
  output slot_t      slot,
  output logic       take
);

  logic valid;
  seg_t seg;

  assign slot = '{valid: valid, seg: seg};
  assign take = !valid || (start_of(new_seg, ctrl.axis) < start_of(seg, ctrl.axis));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && take) begin
      valid <= left_take ? left.valid : 1'b1;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && take) begin
      seg <= left_take ? left.seg : new_seg;
    end else if (ctrl.shift) begin
      seg <= right.seg;
    end
  end

endmodule

### rtl/core/smu_merge.sv
module smu_merge
  import smu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       active,
  input  logic       axis,
  input  slot_t      head,
  input  logic       out_free,
  output logic       pop,
  output merge_out_t emit,
  output logic       done
);

  logic   cur_valid;
  seg_t   cur;
  coord_t cur_end;
  logic   overlap;
  logic   extend;

  assign cur_end = end_of(cur, axis);
  assign overlap = cur_valid && (start_of(head.seg, axis) <= cur_end);
  assign extend  = end_of(head.seg, axis) >= cur_end;

  always_comb begin
    pop       = 1'b0;
    done      = 1'b0;
    emit      = '{valid: 1'b0, last: 1'b0, seg: cur};
    if (active && head.valid) begin
      if (overlap || !cur_valid) begin
        pop = 1'b1;
      end else if (out_free) begin
        pop        = 1'b1;
        emit.valid = 1'b1;
      end
    end else if (active && cur_valid && out_free) begin
      emit.valid = 1'b1;
      emit.last  = 1'b1;
      done       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (overlap) begin
        if (extend) begin
          cur.bx <= head.seg.bx;
          cur.by <= head.seg.by;
        end
      end else begin
        cur <= head.seg;
      end
    end
  end

endmodule

### rtl/core/segment_overlap_merge_unit.sv
// Collects a job of up to MAX_SEGMENTS segments, one beat per cycle, and
// after the beat with tlast set merges the segments that overlap along the
// axis chosen by cfg_wdata (0 X, 1 Y; sampled with the tlast beat). Beats
// past capacity are dropped and every result of that job carries tuser set.
// After the last beat of a job the input stalls while the store is read back
// through its single read port into a sorted chain of cells, one segment a
// cycle, and then while the chain shifts its head into the merge register,
// one segment a cycle, and while the final result is emitted; a stalled
// output holds up the sweep only when a result has to leave. The first beat
// of the next job is taken right after the last result is registered.
module segment_overlap_merge_unit
  import smu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic                 cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [4*FIELD_W-1:0] s_tdata,   // first_x, first_y, second_x, second_y
  input  logic                 s_tlast,   // job_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [4*FIELD_W-1:0] m_tdata,   // start_x, start_y, end_x, end_y
  output logic                 m_tlast,   // final_result
  output logic                 m_tuser    // overflow
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SORT  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             axis_select;
  logic             axis_job;
  logic             dropped;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_ptr;
  logic             rd_issue;
  logic             rd_valid;
  entry_t           mem [MAX_SEGMENTS];
  entry_t           mem_q;
  entry_t           wr_entry;
  logic             beat_in;
  logic             out_free;

  cell_ctrl_t       ctrl;
  seg_t             new_seg;
  slot_t            slots [MAX_SEGMENTS];
  logic             takes [MAX_SEGMENTS];

  logic             pop;
  logic             done;
  merge_out_t       emit;

  assign s_tready = state == ST_LOAD;
  assign beat_in  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_issue = (state == ST_SORT) && (rd_ptr != count);

  always_comb begin
    wr_entry.seg.ax = s_tdata[0*FIELD_W +: COORD_BITS];
    wr_entry.seg.ay = s_tdata[1*FIELD_W +: COORD_BITS];
    wr_entry.seg.bx = s_tdata[2*FIELD_W +: COORD_BITS];
    wr_entry.seg.by = s_tdata[3*FIELD_W +: COORD_BITS];
    wr_entry.swap_x = wr_entry.seg.ax > wr_entry.seg.bx;
    wr_entry.swap_y = wr_entry.seg.ay > wr_entry.seg.by;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select <= 1'b0;
    end else if (cfg_wen) begin
      axis_select <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (beat_in && s_tlast) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (!rd_issue && !rd_valid) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      dropped  <= 1'b0;
      rd_ptr   <= '0;
      rd_valid <= 1'b0;
      axis_job <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_issue;
      if (beat_in) begin
        if (count != CNT_W'(MAX_SEGMENTS)) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
        if (s_tlast) begin
          axis_job <= axis_select;
          rd_ptr   <= '0;
        end
      end
      if (rd_issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (done) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_in && count != CNT_W'(MAX_SEGMENTS)) begin
      mem[count[ADDR_W-1:0]] <= wr_entry;
    end
    if (rd_issue) begin
      mem_q <= mem[rd_ptr[ADDR_W-1:0]];
    end
  end

  assign ctrl    = '{insert: rd_valid, shift: pop, axis: axis_job};
  assign new_seg = orient(mem_q, axis_job);

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    slot_t left;
    slot_t right;
    logic  left_take;

    if (k == 0) begin : g_first
      assign left      = '{valid: 1'b0, seg: new_seg};
      assign left_take = 1'b0;
    end else begin : g_inner
      assign left      = slots[k-1];
      assign left_take = takes[k-1];
    end

    if (k == MAX_SEGMENTS - 1) begin : g_last
      assign right = '{valid: 1'b0, seg: new_seg};
    end else begin : g_body
      assign right = slots[k+1];
    end

    smu_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_seg   (new_seg),
      .left      (left),
      .left_take (left_take),
      .right     (right),
      .slot      (slots[k]),
      .take      (takes[k])
    );
  end

  smu_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .active   (state == ST_MERGE),
    .axis     (axis_job),
    .head     (slots[0]),
    .out_free (out_free),
    .pop      (pop),
    .emit     (emit),
    .done     (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_tdata <= {FIELD_W'(emit.seg.by), FIELD_W'(emit.seg.bx),
                  FIELD_W'(emit.seg.ay), FIELD_W'(emit.seg.ax)};
      m_tlast <= emit.last;
      m_tuser <= dropped;
    end
  end

  a_load_chain_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> !slots[0].valid && !rd_valid)
    else $error("chain holds data while loading");

  a_sort_fills_head: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT && !rd_issue && !rd_valid |=> slots[0].valid)
    else $error("merge started on an empty chain");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT |-> rd_ptr <= count)
    else $error("store read past fill count");

  a_final_ends_job: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.last |=> state == ST_LOAD && count == '0)
    else $error("job not closed after last result");

endmodule
